### rtl/sbr_pkg.sv
// ----------------------------------------------------------------------------
// Shape boundary radius package
// Shared types, register indexes, side codes and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package sbr_pkg;

    localparam int VW = 36;
    localparam int RW = 34;

    localparam logic [2:0] REG_SHAPE_KIND = 3'd0;
    localparam logic [2:0] REG_HALF_X     = 3'd1;
    localparam logic [2:0] REG_HALF_Y     = 3'd2;
    localparam logic [2:0] REG_CENTER_X   = 3'd3;
    localparam logic [2:0] REG_CENTER_Y   = 3'd4;
    localparam logic [2:0] REG_HEADING    = 3'd5;

    localparam logic [2:0] SIDE_RIGHT   = 3'd0;
    localparam logic [2:0] SIDE_LEFT    = 3'd1;
    localparam logic [2:0] SIDE_TOP     = 3'd2;
    localparam logic [2:0] SIDE_BOTTOM  = 3'd3;
    localparam logic [2:0] SIDE_ELLIPSE = 3'd4;

    typedef struct packed {
        logic                 valid;
        logic                 zero;
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic [31:0]          z;
    } vec_t;

    typedef struct packed {
        logic                 valid;
        logic                 neg;
        logic signed [15:0]   r;
        logic signed [15:0]   phi;
        logic signed [RW-1:0] x;
        logic signed [RW-1:0] y;
        logic signed [RW-1:0] z;
    } rot_t;

    typedef struct packed {
        logic        valid;
        logic        sqrt_mode;
        logic        sat;
        logic [2:0]  side;
        logic [35:0] rem;
        logic [63:0] feed;
        logic [32:0] den;
        logic [31:0] q;
    } dig_t;

    function automatic logic [31:0] atan_tab(input logic [4:0] k);
        logic [31:0] v;
        unique case (k)
            5'd0:  v = 32'h20000000;
            5'd1:  v = 32'h12E4051E;
            5'd2:  v = 32'h09FB385B;
            5'd3:  v = 32'h051111D4;
            5'd4:  v = 32'h028B0D43;
            5'd5:  v = 32'h0145D7E1;
            5'd6:  v = 32'h00A2F61E;
            5'd7:  v = 32'h00517C55;
            5'd8:  v = 32'h0028BE53;
            5'd9:  v = 32'h00145F2F;
            5'd10: v = 32'h000A2F98;
            5'd11: v = 32'h000517CC;
            5'd12: v = 32'h00028BE6;
            5'd13: v = 32'h000145F3;
            5'd14: v = 32'h0000A2FA;
            5'd15: v = 32'h0000517D;
            5'd16: v = 32'h000028BE;
            5'd17: v = 32'h0000145F;
            5'd18: v = 32'h00000A30;
            5'd19: v = 32'h00000518;
            5'd20: v = 32'h0000028C;
            5'd21: v = 32'h00000146;
            5'd22: v = 32'h000000A3;
            5'd23: v = 32'h00000051;
            5'd24: v = 32'h00000029;
            5'd25: v = 32'h00000014;
            5'd26: v = 32'h0000000A;
            5'd27: v = 32'h00000005;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            5'd30: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

endpackage

### rtl/sbr_vec_cell.sv
// ----------------------------------------------------------------------------
// Vectoring CORDIC cell
// One registered micro-rotation that drives y toward zero and sums the angle.
// ----------------------------------------------------------------------------
module sbr_vec_cell
    import sbr_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  vec_t d,
    output vec_t q
);

    localparam logic [4:0] K = 5'(STAGE);

    logic signed [VW-1:0] xs;
    logic signed [VW-1:0] ys;
    vec_t                 q_next;

    assign xs = d.x >>> K;
    assign ys = d.y >>> K;

    always_comb
    begin
        q_next = d;
        if (!d.y[VW-1])
        begin
            q_next.x = d.x + ys;
            q_next.y = d.y - xs;
            q_next.z = d.z + atan_tab(K);
        end
        else
        begin
            q_next.x = d.x - ys;
            q_next.y = d.y + xs;
            q_next.z = d.z - atan_tab(K);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q <= '0;
        else if (en)
            q <= q_next;
    end

endmodule

### rtl/sbr_rot_cell.sv
// ----------------------------------------------------------------------------
// Rotation CORDIC cell
// One registered micro-rotation that turns the vector by the residual angle.
// ----------------------------------------------------------------------------
module sbr_rot_cell
    import sbr_pkg::*;
#(
    parameter int STAGE = 0
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  rot_t d,
    output rot_t q
);

    localparam logic [4:0] K = 5'(STAGE);

    logic signed [RW-1:0] xs;
    logic signed [RW-1:0] ys;
    logic signed [RW-1:0] at;
    rot_t                 q_next;

    assign xs = d.x >>> K;
    assign ys = d.y >>> K;
    assign at = $signed({{(RW-32){1'b0}}, atan_tab(K)});

    always_comb
    begin
        q_next = d;
        if (!d.z[RW-1])
        begin
            q_next.x = d.x - ys;
            q_next.y = d.y + xs;
            q_next.z = d.z - at;
        end
        else
        begin
            q_next.x = d.x + ys;
            q_next.y = d.y - xs;
            q_next.z = d.z + at;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q <= '0;
        else if (en)
            q <= q_next;
    end

endmodule

### rtl/sbr_digit_cell.sv
// ----------------------------------------------------------------------------
// Digit recurrence cell
// One registered step of restoring division or of the integer square root.
// ----------------------------------------------------------------------------
module sbr_digit_cell
    import sbr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic en,
    input  dig_t d,
    output dig_t q
);

    logic [35:0] rem2;
    logic [35:0] trial;
    logic        ge;
    dig_t        q_next;

    always_comb
    begin
        q_next = d;
        if (d.sqrt_mode)
        begin
            rem2  = {d.rem[33:0], d.feed[63:62]};
            trial = {2'b00, d.q, 2'b01};
            q_next.feed = {d.feed[61:0], 2'b00};
        end
        else
        begin
            rem2  = {d.rem[34:0], d.feed[63]};
            trial = {3'b000, d.den};
            q_next.feed = {d.feed[62:0], 1'b0};
        end
        ge = (rem2 >= trial);
        q_next.rem = ge ? (rem2 - trial) : rem2;
        q_next.q   = {d.q[30:0], ge};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q <= '0;
        else if (en)
            q <= q_next;
    end

endmodule

### rtl/shape_boundary_radius_core.sv
// ----------------------------------------------------------------------------
// Shape boundary radius core
// Distance from a rotated rectangle's or ellipse's centre to its outline.
// ----------------------------------------------------------------------------
// The core takes one query point per cycle while the output is not stalled and
// returns one result per query, in order. A query passes through the two
// CORDIC chains (vectoring for the ray angle, rotation for cos and sin) and
// the 32-cell digit chain that does both the division and the square root.
// The whole pipeline halts while a result waits at the output.
module shape_boundary_radius_core
    import sbr_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,    // query_x, query_y
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // bound_radius
    output logic [3:0]  m_tuser,    // side_hit, saturated
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int DIGITS = 32;
    localparam logic signed [RW-1:0] CORDIC_X0 = RW'(652032874);

    logic               kind_reg;
    logic [31:0]        half_x_reg;
    logic [31:0]        half_y_reg;
    logic signed [31:0] center_x_reg;
    logic signed [31:0] center_y_reg;
    logic signed [15:0] heading_reg;

    logic en;

    vec_t vchain [0:CORDIC_STAGES];
    vec_t pchain [0:CORDIC_STAGES];
    rot_t rchain [0:CORDIC_STAGES];
    dig_t dchain [0:DIGITS];

    logic signed [32:0] dx;
    logic signed [32:0] dy;
    vec_t               vec_in_next;
    vec_t               phi_in;

    logic               ang_valid_reg;
    logic signed [15:0] ang_r_reg;
    logic signed [15:0] ang_phi_reg;
    logic signed [15:0] ang_r_next;
    logic signed [15:0] ang_phi_next;
    logic [31:0]        theta_sum;
    logic [31:0]        phi_sum;
    logic signed [15:0] phi_raw;

    logic signed [15:0] r_fold;

    logic signed [RW-1:0] c_val;
    logic signed [RW-1:0] s_val;
    logic signed [16:0]   r17;
    logic signed [16:0]   a17;
    logic signed [16:0]   p17;
    logic signed [16:0]   lim17;
    logic signed [34:0]   den35;
    logic [31:0]          half_sel;
    logic [2:0]           side_sel;
    logic [33:0]          c_mag;
    logic [33:0]          s_mag;
    logic                 rect_sat;

    logic        p1_valid_reg, p2_valid_reg, p3_valid_reg;
    logic        p1_kind_reg, p2_kind_reg, p3_kind_reg;
    logic        p1_sat_reg, p2_sat_reg, p3_sat_reg;
    logic [2:0]  p1_side_reg, p2_side_reg, p3_side_reg;
    logic [32:0] p1_den_reg, p2_den_reg, p3_den_reg;
    logic [31:0] p1_half_reg, p2_half_reg, p3_half_reg;
    logic [65:0] p1_e1_reg, p1_e2_reg;
    logic [65:0] e1_rnd, e2_rnd;
    logic [31:0] p2_t1_reg, p2_t2_reg;
    logic [63:0] p3_q1_reg, p3_q2_reg;
    logic [64:0] sq_sum;
    dig_t        dig_in_next;

    logic        out_valid_reg;
    logic [31:0] out_dist_reg;
    logic [2:0]  out_side_reg;
    logic        out_sat_reg;

    assign en        = !out_valid_reg || m_tready;
    assign s_tready  = en;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kind_reg     <= 1'b0;
            half_x_reg   <= 32'd65536;
            half_y_reg   <= 32'd65536;
            center_x_reg <= '0;
            center_y_reg <= '0;
            heading_reg  <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_SHAPE_KIND: kind_reg     <= cfg_data[0];
                REG_HALF_X:     half_x_reg   <= cfg_data;
                REG_HALF_Y:     half_y_reg   <= cfg_data;
                REG_CENTER_X:   center_x_reg <= cfg_data;
                REG_CENTER_Y:   center_y_reg <= cfg_data;
                REG_HEADING:    heading_reg  <= cfg_data[15:0];
                default:        ;
            endcase
        end
    end

    // Offset from the centre, folded into the right half plane.
    always_comb
    begin
        dx = 33'(signed'(s_tdata[31:0])) - 33'(center_x_reg);
        dy = 33'(signed'(s_tdata[63:32])) - 33'(center_y_reg);
        vec_in_next.valid = s_tvalid;
        vec_in_next.zero  = (dx == '0) && (dy == '0);
        if (dx[32])
        begin
            vec_in_next.x = -VW'(dx);
            vec_in_next.y = -VW'(dy);
            vec_in_next.z = 32'h80000000;
        end
        else
        begin
            vec_in_next.x = VW'(dx);
            vec_in_next.y = VW'(dy);
            vec_in_next.z = 32'h0;
        end
    end

    always_comb
    begin
        phi_in.valid = vchain[0].valid;
        phi_in.zero  = (half_x_reg == '0) && (half_y_reg == '0);
        phi_in.x     = VW'({1'b0, half_x_reg});
        phi_in.y     = VW'({1'b0, half_y_reg});
        phi_in.z     = 32'h0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vchain[0] <= '0;
            pchain[0] <= '0;
        end
        else if (en)
        begin
            vchain[0] <= vec_in_next;
            pchain[0] <= phi_in;
        end
    end

    genvar gi;
    generate
        for (gi = 0; gi < CORDIC_STAGES; gi++)
        begin : g_vec
            sbr_vec_cell #(.STAGE(gi)) u_ray (
                .clk(clk), .rst_n(rst_n), .en(en), .d(vchain[gi]), .q(vchain[gi+1])
            );
            sbr_vec_cell #(.STAGE(gi)) u_phi (
                .clk(clk), .rst_n(rst_n), .en(en), .d(pchain[gi]), .q(pchain[gi+1])
            );
        end
    endgenerate

    // Round both angles to binary angles; subtract the heading; clamp phi to a quarter turn.
    always_comb
    begin
        theta_sum  = vchain[CORDIC_STAGES].z + 32'h8000;
        phi_sum    = pchain[CORDIC_STAGES].z + 32'h8000;
        ang_r_next = vchain[CORDIC_STAGES].zero ? 16'sd0 : signed'(theta_sum[31:16]);
        ang_r_next = ang_r_next - heading_reg;
        phi_raw    = pchain[CORDIC_STAGES].zero ? 16'sd0 : signed'(phi_sum[31:16]);
        if (phi_raw < 16'sd0)
            ang_phi_next = 16'sd0;
        else if (phi_raw > 16'sd16384)
            ang_phi_next = 16'sd16384;
        else
            ang_phi_next = phi_raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ang_valid_reg <= 1'b0;
        else if (en)
            ang_valid_reg <= vchain[CORDIC_STAGES].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_r_reg   <= ang_r_next;
            ang_phi_reg <= ang_phi_next;
        end
    end

    // Fold the angle into a half turn around zero before the rotation chain.
    always_comb
    begin
        rchain[0].valid = ang_valid_reg;
        rchain[0].r     = ang_r_reg;
        rchain[0].phi   = ang_phi_reg;
        rchain[0].x     = CORDIC_X0;
        rchain[0].y     = '0;
        if (ang_r_reg > 16'sd16384)
        begin
            r_fold       = ang_r_reg - 16'sd32767 - 16'sd1;
            rchain[0].neg = 1'b1;
        end
        else if (ang_r_reg < -16'sd16384)
        begin
            r_fold       = ang_r_reg + 16'sd32767 + 16'sd1;
            rchain[0].neg = 1'b1;
        end
        else
        begin
            r_fold       = ang_r_reg;
            rchain[0].neg = 1'b0;
        end
        rchain[0].z = signed'({{(RW-32){r_fold[15]}}, r_fold, 16'h0000});
    end

    generate
        for (gi = 0; gi < CORDIC_STAGES; gi++)
        begin : g_rot
            sbr_rot_cell #(.STAGE(gi)) u_rot (
                .clk(clk), .rst_n(rst_n), .en(en), .d(rchain[gi]), .q(rchain[gi+1])
            );
        end
    endgenerate

    // Side selection for the rectangle, scaled terms for the ellipse.
    always_comb
    begin
        c_val = rchain[CORDIC_STAGES].neg ? -rchain[CORDIC_STAGES].x
                                          : rchain[CORDIC_STAGES].x;
        s_val = rchain[CORDIC_STAGES].neg ? -rchain[CORDIC_STAGES].y
                                          : rchain[CORDIC_STAGES].y;
        r17   = 17'(rchain[CORDIC_STAGES].r);
        a17   = r17[16] ? -r17 : r17;
        p17   = 17'(rchain[CORDIC_STAGES].phi);
        lim17 = 17'sd32768 - p17;
        priority if (a17 <= p17)
        begin
            side_sel = SIDE_RIGHT;
            den35    = 35'(c_val);
            half_sel = half_x_reg;
        end
        else if (a17 >= lim17)
        begin
            side_sel = SIDE_LEFT;
            den35    = -35'(c_val);
            half_sel = half_x_reg;
        end
        else if (r17 >= p17 && r17 <= lim17)
        begin
            side_sel = SIDE_TOP;
            den35    = 35'(s_val);
            half_sel = half_y_reg;
        end
        else
        begin
            side_sel = SIDE_BOTTOM;
            den35    = -35'(s_val);
            half_sel = half_y_reg;
        end
        rect_sat = (den35 <= 35'sd0) ||
                   ({3'b000, half_sel} >= {den35[32:0], 2'b00});
        c_mag = c_val[RW-1] ? 34'(-c_val) : 34'(c_val);
        s_mag = s_val[RW-1] ? 34'(-s_val) : 34'(s_val);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg <= 1'b0;
            p2_valid_reg <= 1'b0;
            p3_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            p1_valid_reg <= rchain[CORDIC_STAGES].valid;
            p2_valid_reg <= p1_valid_reg;
            p3_valid_reg <= p2_valid_reg;
        end
    end

    assign e1_rnd = p1_e1_reg + 66'h20000000;
    assign e2_rnd = p1_e2_reg + 66'h20000000;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_kind_reg <= kind_reg;
            p1_side_reg <= kind_reg ? SIDE_ELLIPSE : side_sel;
            p1_sat_reg  <= kind_reg ? 1'b0 : rect_sat;
            p1_den_reg  <= den35[32:0];
            p1_half_reg <= half_sel;
            p1_e1_reg   <= 66'(half_x_reg) * 66'(c_mag);
            p1_e2_reg   <= 66'(half_y_reg) * 66'(s_mag);

            p2_kind_reg <= p1_kind_reg;
            p2_side_reg <= p1_side_reg;
            p2_sat_reg  <= p1_sat_reg ||
                           (p1_kind_reg && (e1_rnd[65:62] != '0 || e2_rnd[65:62] != '0));
            p2_den_reg  <= p1_den_reg;
            p2_half_reg <= p1_half_reg;
            p2_t1_reg   <= e1_rnd[61:30];
            p2_t2_reg   <= e2_rnd[61:30];

            p3_kind_reg <= p2_kind_reg;
            p3_side_reg <= p2_side_reg;
            p3_sat_reg  <= p2_sat_reg;
            p3_den_reg  <= p2_den_reg;
            p3_half_reg <= p2_half_reg;
            p3_q1_reg   <= 64'(p2_t1_reg) * 64'(p2_t2_reg == p2_t2_reg ? p2_t1_reg : '0);
            p3_q2_reg   <= 64'(p2_t2_reg) * 64'(p2_t2_reg);
        end
    end

    // Set up the digit chain: square root for the ellipse, division otherwise.
    always_comb
    begin
        sq_sum = {1'b0, p3_q1_reg} + {1'b0, p3_q2_reg};
        dig_in_next.valid     = p3_valid_reg;
        dig_in_next.sqrt_mode = p3_kind_reg;
        dig_in_next.side      = p3_side_reg;
        dig_in_next.den       = p3_den_reg;
        dig_in_next.q         = '0;
        if (p3_kind_reg)
        begin
            dig_in_next.sat  = p3_sat_reg || sq_sum[64];
            dig_in_next.rem  = '0;
            dig_in_next.feed = sq_sum[63:0];
        end
        else
        begin
            dig_in_next.sat  = p3_sat_reg;
            dig_in_next.rem  = {6'b000000, p3_half_reg[31:2]};
            dig_in_next.feed = {p3_half_reg[1:0], 62'h0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dchain[0] <= '0;
        else if (en)
            dchain[0] <= dig_in_next;
    end

    generate
        for (gi = 0; gi < DIGITS; gi++)
        begin : g_dig
            sbr_digit_cell u_dig (
                .clk(clk), .rst_n(rst_n), .en(en), .d(dchain[gi]), .q(dchain[gi+1])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dchain[DIGITS].valid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_dist_reg <= dchain[DIGITS].sat ? 32'hFFFFFFFF : dchain[DIGITS].q;
            out_side_reg <= dchain[DIGITS].side;
            out_sat_reg  <= dchain[DIGITS].sat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_dist_reg;
    assign m_tuser  = {out_sat_reg, out_side_reg};

`ifndef NO_ASSERTIONS
    a_sat_all_ones: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_sat_reg |-> out_dist_reg == 32'hFFFFFFFF)
        else $error("Saturated result without full-scale distance.");

    a_side_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_side_reg <= SIDE_ELLIPSE)
        else $error("Side code out of range.");

    a_side_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_side_reg == SIDE_ELLIPSE) == kind_reg))
        else $error("Side code does not match the shape kind.");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready |=> $stable(out_dist_reg) && $stable(out_side_reg))
        else $error("Pipeline advanced while the output was stalled.");
`endif

endmodule
